[rtl/esckp_pkg.sv]
// ----------------------------------------------------------------------------
// esckp_pkg
// Types and byte constants shared by the escape sequence key parser.
// ----------------------------------------------------------------------------
package esckp_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_FKEY = 3'd1,
    KIND_CSI  = 3'd2,
    KIND_PF   = 3'd3,
    KIND_ESC  = 3'd4
  } kind_t;

  // sequence modes of the back end
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_ESC_FIRST = 3'd1,
    MODE_ESC_INTER = 3'd2,
    MODE_PF        = 3'd3,
    MODE_CSI       = 3'd4
  } mode_t;

  // byte classes found by the front end
  typedef enum logic [2:0] {
    CLS_INTER = 3'd0,  // 0x20-0x2f
    CLS_DIGIT = 3'd1,  // 0x30-0x39
    CLS_SEMI  = 3'd2,  // ';'
    CLS_PRIV  = 3'd3,  // other 0x3a-0x3f
    CLS_FINAL = 3'd4,  // 0x40-0x7e
    CLS_BAD   = 3'd5
  } cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       timed_out;
    cls_t       cls;
    logic       csi_open;   // 8-bit csi opener
    logic       is_lbrack;
    logic       is_pf;
    logic       is_tilde;
  } entry_t;

  localparam logic [7:0] BYTE_CSI8   = 8'h9B;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_PF     = 8'h4F;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] INTER_LO    = 8'h20;
  localparam logic [7:0] INTER_HI    = 8'h2F;
  localparam logic [7:0] PARAM_LO    = 8'h30;
  localparam logic [7:0] DIGIT_HI    = 8'h39;
  localparam logic [7:0] PARAM_HI    = 8'h3F;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  localparam logic signed [16:0] CODE_NONE = 17'h1FFFF;

endpackage

[rtl/esckp_if.sv]
// ----------------------------------------------------------------------------
// esckp_in_if / esckp_out_if
// Valid/ready channels for received bytes and decoded keys.
// ----------------------------------------------------------------------------
interface esckp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;
  logic       timed_out;

  modport source (output valid, output data_byte, output start_req, output timed_out,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input timed_out,
                  output ready);
endinterface

interface esckp_out_if;
  logic                   valid;
  logic                   ready;
  esckp_pkg::kind_t       key_kind;
  logic signed [16:0]     key_code;
  logic                   status;

  modport source (output valid, output key_kind, output key_code, output status,
                  input ready);
  modport sink   (input valid, input key_kind, input key_code, input status,
                  output ready);
endinterface

[rtl/esckp_front.sv]
// ----------------------------------------------------------------------------
// esckp_front
// Accepts received words and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module esckp_front (
  esckp_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             q_push,
  output esckp_pkg::entry_t q_entry
);
  import esckp_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    logic [7:0] b;
    b = in_ch.data_byte;
    q_entry.data_byte = b;
    q_entry.start_req = in_ch.start_req;
    q_entry.timed_out = in_ch.timed_out;
    q_entry.csi_open  = (b == BYTE_CSI8);
    q_entry.is_lbrack = (b == BYTE_LBRACK);
    q_entry.is_pf     = (b == BYTE_PF);
    q_entry.is_tilde  = (b == BYTE_TILDE);
    if (b >= INTER_LO && b <= INTER_HI) begin
      q_entry.cls = CLS_INTER;
    end else if (b >= PARAM_LO && b <= DIGIT_HI) begin
      q_entry.cls = CLS_DIGIT;
    end else if (b == BYTE_SEMI) begin
      q_entry.cls = CLS_SEMI;
    end else if (b > DIGIT_HI && b <= PARAM_HI) begin
      q_entry.cls = CLS_PRIV;
    end else if (b >= FINAL_LO && b <= FINAL_HI) begin
      q_entry.cls = CLS_FINAL;
    end else begin
      q_entry.cls = CLS_BAD;
    end
  end

endmodule

[rtl/esckp_queue.sv]
// ----------------------------------------------------------------------------
// esckp_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module esckp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  esckp_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output esckp_pkg::entry_t head
);
  import esckp_pkg::*;

  entry_t     slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");

endmodule

[rtl/esckp_back.sv]
// ----------------------------------------------------------------------------
// esckp_back
// Sequence state machine, leading parameter accumulator and result register.
// ----------------------------------------------------------------------------
module esckp_back #(
  parameter int MAX_SEQ_LEN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  esckp_pkg::entry_t q_head,
  output logic              q_pop,
  esckp_out_if.source       out_ch
);
  import esckp_pkg::*;

  localparam int CW = $clog2(MAX_SEQ_LEN + 1);
  localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_SEQ_LEN);

  mode_t              mode_r, mode_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [15:0]        value_r, value_nxt;
  logic               has_digit_r, has_digit_nxt;
  logic               closed_r, closed_nxt;
  logic               bad_r, bad_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic signed [16:0] out_code_r;
  logic               out_status_r;

  logic               done;
  kind_t              kind;
  logic signed [16:0] code;
  logic               status;
  logic               out_free;
  logic [CW-1:0]      cnt_inc;
  logic [19:0]        acc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_inc  = cnt_r + CW'(1);
  // value * 10 + digit
  assign acc = ({4'd0, value_r} << 3) + ({4'd0, value_r} << 1)
             + {16'd0, q_head.data_byte[3:0]};

  always_comb begin
    done          = 1'b0;
    kind          = KIND_NONE;
    code          = CODE_NONE;
    status        = 1'b0;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    value_nxt     = value_r;
    has_digit_nxt = has_digit_r;
    closed_nxt    = closed_r;
    bad_nxt       = bad_r;

    if (q_head.timed_out) begin
      if (mode_r != MODE_IDLE) begin
        done   = 1'b1;
        kind   = (mode_r == MODE_PF) ? KIND_PF : KIND_NONE;
        status = 1'b1;
      end
    end else if (q_head.start_req) begin
      cnt_nxt       = '0;
      value_nxt     = '0;
      has_digit_nxt = 1'b0;
      closed_nxt    = 1'b0;
      bad_nxt       = 1'b0;
      mode_nxt      = q_head.csi_open ? MODE_CSI : MODE_ESC_FIRST;
    end else if (mode_r != MODE_IDLE) begin
      cnt_nxt = cnt_inc;
      unique case (mode_r)
        MODE_ESC_FIRST, MODE_ESC_INTER: begin
          if (mode_r == MODE_ESC_FIRST && q_head.is_lbrack) begin
            mode_nxt = MODE_CSI;
          end else if (mode_r == MODE_ESC_FIRST && q_head.is_pf) begin
            mode_nxt = MODE_PF;
          end else if (q_head.cls inside {CLS_DIGIT, CLS_SEMI, CLS_PRIV, CLS_FINAL}) begin
            done = 1'b1;
            kind = KIND_ESC;
            code = {9'd0, q_head.data_byte};
          end else if (q_head.cls == CLS_INTER) begin
            mode_nxt = MODE_ESC_INTER;
          end else begin
            done = 1'b1;
          end
        end
        MODE_PF: begin
          done = 1'b1;
          kind = KIND_PF;
          code = {9'd0, q_head.data_byte};
        end
        MODE_CSI: begin
          unique case (q_head.cls)
            CLS_FINAL: begin
              done = 1'b1;
              if (!bad_r) begin
                kind = q_head.is_tilde ? KIND_FKEY : KIND_CSI;
                code = has_digit_r ? {1'b0, value_r} : {9'd0, q_head.data_byte};
              end
            end
            CLS_INTER: closed_nxt = 1'b1;
            CLS_DIGIT: begin
              if (!closed_r) begin
                value_nxt     = (|acc[19:16]) ? 16'hFFFF : acc[15:0];
                has_digit_nxt = 1'b1;
              end
            end
            CLS_SEMI: begin
              if (!closed_r) begin
                if (!has_digit_r) begin
                  bad_nxt = 1'b1;
                end
                closed_nxt = 1'b1;
              end
            end
            CLS_PRIV: begin
              if (!closed_r) begin
                bad_nxt = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
        default: ;
      endcase
      // length limit
      if (!done && cnt_inc >= LEN_LIMIT) begin
        done = 1'b1;
      end
    end

    if (done) begin
      mode_nxt      = MODE_IDLE;
      cnt_nxt       = '0;
      value_nxt     = '0;
      has_digit_nxt = 1'b0;
      closed_nxt    = 1'b0;
      bad_nxt       = 1'b0;
    end
  end

  // a word that ends a sequence waits for room in the result register
  assign q_pop = !q_empty && (!done || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cnt_r       <= '0;
      value_r     <= '0;
      has_digit_r <= 1'b0;
      closed_r    <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r      <= mode_nxt;
        cnt_r       <= cnt_nxt;
        value_r     <= value_nxt;
        has_digit_r <= has_digit_nxt;
        closed_r    <= closed_nxt;
        bad_r       <= bad_nxt;
      end
      if (q_pop && done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && done) begin
      out_kind_r   <= kind;
      out_code_r   <= code;
      out_status_r <= status;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_kind = out_kind_r;
  assign out_ch.key_code = out_code_r;
  assign out_ch.status   = out_status_r;

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && done) |=> (mode_r == MODE_IDLE))
    else $error("sequence end did not return to idle");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (cnt_r == '0 && !has_digit_r && !bad_r && !closed_r))
    else $error("sequence state left over in idle");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < LEN_LIMIT)
    else $error("byte count reached the length limit");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

[rtl/escape_sequence_key_parser_core.sv]
// ----------------------------------------------------------------------------
// escape_sequence_key_parser_core
// Byte-wise classifier of keyboard escape and csi control sequences.
// ----------------------------------------------------------------------------
// an ending word is queued, and its key is then registered for output
// throughput: one word per cycle while the output keeps up; classifier,
//   2-entry queue and sequence machine each take one word per cycle
// a key waiting on a stalled output blocks the next sequence-ending word and those behind it
// reset: synchronous active-low rst_n empties the queue and result register
//   and returns the parser to idle
module escape_sequence_key_parser_core #(
  parameter int MAX_SEQ_LEN = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  esckp_in_if.sink     in_ch,
  esckp_out_if.source  out_ch
);
  import esckp_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  esckp_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  esckp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  esckp_back #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte words with start and timeout flags into the escape sequence key
// parser, predicts the decoded keys in step with each accepted word and checks
// every key that comes out, under several patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module testbench;
  import esckp_pkg::*;

  localparam int MAX_LEN = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 170;
  localparam logic [7:0] ESC_BYTE = 8'h1B;

  typedef struct {
    logic [7:0] data_byte;
    logic       start_req;
    logic       timed_out;
    int         phase;
    bit         hold;
  } word_t;

  typedef struct {
    kind_t              kind;
    logic signed [16:0] code;
    logic               status;
  } key_t;

  logic clk;
  logic rst_n;
  logic in_fired;

  esckp_in_if  in_ch();
  esckp_out_if out_ch();

  escape_sequence_key_parser_core #(.MAX_SEQ_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t pending_words[$];
  key_t  expected_keys[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    cur_phase = 0;
  int    gen_phase = 0;
  bit    gen_hold = 0;
  int    send_idle[4]  = '{0, 51, 0, 24};
  int    recv_stall[4] = '{0, 0, 51, 24};

  // parser state as predicted
  mode_t seq_mode = MODE_IDLE;
  int    seq_len = 0;
  int    par_val = 0;
  int    par_digits = 0;
  bit    par_closed = 0;
  bit    par_bad = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic clear_seq();
    seq_len = 0;
    par_val = 0;
    par_digits = 0;
    par_closed = 0;
    par_bad = 0;
  endtask

  // advance the predicted parser by one accepted word
  task automatic track_byte(input logic [7:0] b, input logic st, input logic tmo);
    key_t k;
    bit done;
    k.kind = KIND_NONE;
    k.code = CODE_NONE;
    k.status = 1'b0;
    done = 0;
    if (tmo) begin
      if (seq_mode != MODE_IDLE) begin
        if (seq_mode == MODE_PF) k.kind = KIND_PF;
        k.status = 1'b1;
        expected_keys.push_back(k);
        seq_mode = MODE_IDLE;
        clear_seq();
      end
    end else if (st) begin
      clear_seq();
      if (b == BYTE_CSI8) seq_mode = MODE_CSI;
      else seq_mode = MODE_ESC_FIRST;
    end else if (seq_mode != MODE_IDLE) begin
      seq_len++;
      if (seq_mode == MODE_ESC_FIRST && b == BYTE_LBRACK) begin
        seq_mode = MODE_CSI;
      end else if (seq_mode == MODE_ESC_FIRST && b == BYTE_PF) begin
        seq_mode = MODE_PF;
      end else if (seq_mode == MODE_PF) begin
        done = 1;
        k.kind = KIND_PF;
        k.code = {9'd0, b};
      end else if (seq_mode == MODE_ESC_FIRST || seq_mode == MODE_ESC_INTER) begin
        if (b >= PARAM_LO && b <= FINAL_HI) begin
          done = 1;
          k.kind = KIND_ESC;
          k.code = {9'd0, b};
        end else if (b >= INTER_LO && b <= INTER_HI) begin
          seq_mode = MODE_ESC_INTER;
        end else begin
          done = 1;
        end
      end else begin
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          done = 1;
          if (!par_bad) begin
            if (b == BYTE_TILDE) k.kind = KIND_FKEY;
            else k.kind = KIND_CSI;
            if (par_digits == 0) k.code = {9'd0, b};
            else k.code = {1'b0, par_val[15:0]};
          end
        end else if (b >= INTER_LO && b <= INTER_HI) begin
          par_closed = 1;
        end else if (b >= PARAM_LO && b <= PARAM_HI) begin
          if (!par_closed) begin
            if (b <= DIGIT_HI) begin
              par_val = par_val * 10 + int'(b - PARAM_LO);
              if (par_val > 65535) par_val = 65535;
              if (par_digits < 511) par_digits++;
            end else if (b == BYTE_SEMI) begin
              if (par_digits == 0) par_bad = 1;
              par_closed = 1;
            end else begin
              par_bad = 1;
            end
          end
        end else begin
          done = 1;
        end
      end
      if (!done && seq_len >= MAX_LEN) done = 1;
      if (done) begin
        expected_keys.push_back(k);
        seq_mode = MODE_IDLE;
        clear_seq();
      end
    end
  endtask

  // ---- stimulus building ----

  task automatic add_word(input logic [7:0] b, input logic st = 1'b0,
                          input logic tmo = 1'b0);
    word_t w;
    w.data_byte = b;
    w.start_req = st;
    w.timed_out = tmo;
    w.phase = gen_phase;
    w.hold = gen_hold;
    gen_hold = 0;
    pending_words.push_back(w);
  endtask

  task automatic open_esc();
    // now and then an odd opening byte, which counts as esc unless it is the 8-bit csi opener
    if ($urandom_range(7) == 0) add_word(8'($urandom_range(255)), 1'b1);
    else add_word(ESC_BYTE, 1'b1);
  endtask

  task automatic open_csi();
    if ($urandom_range(1)) begin
      add_word(BYTE_CSI8, 1'b1);
    end else begin
      add_word(ESC_BYTE, 1'b1);
      add_word(BYTE_LBRACK);
    end
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) add_word(8'($urandom_range(8'h30, 8'h39)));
  endtask

  task automatic csi_body();
    int groups;
    case ($urandom_range(9))
      0, 1: ;
      2, 3, 4, 5, 6: add_digits($urandom_range(1, 5));
      7: add_digits($urandom_range(6, 9));   // can push the value into saturation
      8: add_word(BYTE_SEMI);
      default: begin
        add_word(8'($urandom_range(8'h3A, 8'h3F)));
        add_digits($urandom_range(0, 2));
      end
    endcase
    groups = $urandom_range(0, 3);
    for (int g = 0; g < groups; g++) begin
      if ($urandom_range(3) == 0) add_word(8'($urandom_range(8'h30, 8'h3F)));
      else add_word(BYTE_SEMI);
      add_digits($urandom_range(0, 3));
    end
    groups = $urandom_range(0, 2);
    for (int g = 0; g < groups; g++) add_word(8'($urandom_range(INTER_LO, INTER_HI)));
    // parameter bytes after the cut are ignored
    if (groups != 0 && $urandom_range(5) == 0)
      add_word(8'($urandom_range(PARAM_LO, PARAM_HI)));
  endtask

  task automatic csi_final();
    if ($urandom_range(9) < 4) add_word(BYTE_TILDE);
    else add_word(8'($urandom_range(FINAL_LO, FINAL_HI)));
  endtask

  // ends an open sequence the hard way
  task automatic break_seq();
    case ($urandom_range(2))
      0: begin
        if ($urandom_range(1)) add_word(8'($urandom_range(8'h00, 8'h1F)));
        else add_word(8'($urandom_range(8'h7F, 8'hFF)));
      end
      1: add_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      default: ;   // the next opener drops this sequence
    endcase
  endtask

  task automatic gen_sequence();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 8) begin
      add_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end else if (r < 18) begin
      open_esc();
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) add_word(8'($urandom_range(INTER_LO, INTER_HI)));
      add_word(8'($urandom_range(PARAM_LO, FINAL_HI)));
    end else if (r < 28) begin
      open_esc();
      add_word(BYTE_PF);
      if ($urandom_range(7) == 0) add_word(8'($urandom_range(255)), 1'b0, 1'b1);
      else add_word(8'($urandom_range(255)));
    end else if (r < 86) begin
      open_csi();
      csi_body();
      csi_final();
    end else begin
      if ($urandom_range(2) == 0) begin
        open_esc();
        if ($urandom_range(1)) add_word(BYTE_PF);
      end else begin
        open_csi();
        csi_body();
      end
      break_seq();
    end
  endtask

  // sequences that run up to the length limit
  task automatic long_run(input int kind);
    if (kind == 1) add_word(ESC_BYTE, 1'b1);
    else add_word(BYTE_CSI8, 1'b1);
    case (kind)
      0: add_digits(MAX_LEN);
      1: for (int i = 0; i < MAX_LEN; i++)
           add_word(8'($urandom_range(INTER_LO, INTER_HI)));
      2: for (int i = 0; i < MAX_LEN; i++)
           add_word(8'($urandom_range(INTER_LO, PARAM_HI)));
      default: begin
        // final byte lands on the very last allowed position
        for (int i = 0; i < MAX_LEN - 1; i++)
          add_word(8'($urandom_range(PARAM_LO, PARAM_HI)));
        csi_final();
      end
    endcase
  endtask

  // ---- driver: words change at the falling edge ----
  always @(negedge clk) begin
    word_t w;
    if (rst_n) begin
      if (!in_ch.valid || in_fired) begin
        if (pending_words.size() != 0
            && !(pending_words[0].hold && expected_keys.size() != 0)
            && $urandom_range(99) >= send_idle[pending_words[0].phase]) begin
          w = pending_words.pop_front();
          cur_phase = w.phase;
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= w.data_byte;
          in_ch.start_req <= w.start_req;
          in_ch.timed_out <= w.timed_out;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall[cur_phase]);
    end
  end

  // ---- monitor and predictor at the rising edge ----
  always @(posedge clk) begin
    key_t want;
    cycle_count++;
    in_fired <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("key kind %0d code %0d status %0d with none expected",
                                    out_ch.key_kind, out_ch.key_code, out_ch.status));
        end else begin
          want = expected_keys.pop_front();
          if (out_ch.key_kind !== want.kind || out_ch.key_code !== want.code
              || out_ch.status !== want.status)
            report_mismatch($sformatf("got kind %0d code %0d status %0d, want %0d %0d %0d",
                                      out_ch.key_kind, out_ch.key_code, out_ch.status,
                                      want.kind, want.code, want.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        track_byte(in_ch.data_byte, in_ch.start_req, in_ch.timed_out);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words and %0d keys outstanding",
               cycle_count, pending_words.size(), expected_keys.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int base;
    rst_n = 1'b0;
    in_fired = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.start_req = 1'b0;
    in_ch.timed_out = 1'b0;
    out_ch.ready = 1'b1;

    // directed words
    add_word(8'hA5, 1'b0, 1'b1);                 // timeout while idle
    add_word(8'hFF);                             // stray byte while idle
    add_word(ESC_BYTE, 1'b1); add_word(BYTE_LBRACK); add_word(8'h41);
    add_word(BYTE_CSI8, 1'b1); add_digits(7); add_word(BYTE_TILDE);
    add_word(ESC_BYTE, 1'b1); add_word(BYTE_PF); add_word(8'h50);
    add_word(ESC_BYTE, 1'b1); add_word(8'h30);
    add_word(BYTE_CSI8, 1'b1); add_word(BYTE_SEMI); add_word(8'h48);
    add_word(BYTE_CSI8, 1'b1); add_word(8'h3F); add_word(8'h68);
    add_word(ESC_BYTE, 1'b1); add_word(8'h01);  // bad byte
    add_word(ESC_BYTE, 1'b1); add_word(BYTE_PF); add_word(8'h00, 1'b0, 1'b1);
    add_word(BYTE_CSI8, 1'b1); add_word(8'h5A, 1'b1); add_word(8'h2F); add_word(8'h7E);
    add_word(BYTE_CSI8, 1'b1); add_word(8'h20); add_word(8'h40);

    for (int p = 0; p < 4; p++) begin
      gen_phase = p;
      gen_hold = 1;
      long_run(p);
      base = pending_words.size();
      while (pending_words.size() - base < PHASE_WORDS) gen_sequence();
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/esckp_pkg.sv
rtl/esckp_if.sv
rtl/esckp_front.sv
rtl/esckp_queue.sv
rtl/esckp_back.sv
rtl/escape_sequence_key_parser_core.sv
test/testbench.sv
